### sv/v8mbs_pkg.sv
// Shared types, constants and helper functions for the V.8 menu bit sequencer.
// No dependencies; imported by every module of the block.
package v8mbs_pkg;

   // item codes carried in req_tuser
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_NEXT  = 1'b1;

   localparam logic [7:0] SYNC_OCTET      = 8'hE0;
   localparam logic [7:0] CALL_FUNC_OCTET = 8'h06 | (8'h01 << 3);
   localparam logic [7:0] MOD_HIGH_OCTET  = 8'h10;
   localparam logic [7:0] ZERO_OCTET      = 8'h00;

   localparam logic [4:0] PREAMBLE_ONES = 5'd20;
   localparam logic [3:0] MENU_OCTETS   = 4'd12;
   localparam logic [4:0] CJ_OCTETS     = 5'd3;
   localparam logic [7:0] CJ_TRAILER    = 8'd8;
   localparam logic [3:0] OCTET_LAST    = 4'd8;   // start bit plus 8 data bits
   localparam logic [5:0] RECIP_NINE    = 6'd57;  // x*57>>9 == x/9 for x < 256

   // order of the four octets within one menu group
   localparam logic [1:0] OCT_SYNC = 2'd0;
   localparam logic [1:0] OCT_CALL = 2'd1;
   localparam logic [1:0] OCT_MODL = 2'd2;
   localparam logic [1:0] OCT_MODH = 2'd3;

   typedef struct packed {
      logic       cj;        // CM terminator layout
      logic [7:0] total;     // bits in the message
      logic [4:0] edge_pos;  // menu: ones below it; CJ: ones from it on
   } plan_type;

   typedef struct packed {
      logic       bit_res;
      logic [7:0] bit_index;
      logic       last;
   } result_type;

   function automatic logic [4:0] div9(input logic [7:0] x);
      logic [13:0] prod;
      prod = {6'b0, x} * {8'b0, RECIP_NINE};
      return prod[13:9];
   endfunction

   function automatic logic [1:0] group_of(input logic [2:0] standard);
      logic [1:0] g;
      case (standard)
         3'd0:          g = 2'd0;
         3'd1, 3'd2:    g = 2'd1;
         3'd3, 3'd4:    g = 2'd2;
         default:       g = 2'd3;
      endcase
      return g;
   endfunction

   function automatic logic [7:0] mod_low(input logic [1:0] group);
      logic [7:0] o;
      case (group)
         2'd0:    o = 8'h00;
         2'd1:    o = 8'h08;
         2'd2:    o = 8'h0C;
         default: o = 8'h0E;
      endcase
      return o;
   endfunction

endpackage

### sv/v8mbs_plan.sv
// Message layout from a start item: total length and the ones/octets boundary.
// Depends on v8mbs_pkg.
module v8mbs_plan import v8mbs_pkg::*; (
   input  logic       cj,
   input  logic [7:0] bit_limit,
   output plan_type   plan
);

   logic [4:0] pre;
   logic [7:0] rem_m;
   logic [4:0] q_m;
   logic [3:0] oct_m;
   logic [7:0] total_m;
   logic [4:0] q_c;
   logic [4:0] cjb;
   logic [7:0] rem_c;
   logic [7:0] trl;
   logic [7:0] total_c;

   always_comb begin
      // CM / JM: preamble clipped first, then whole octets
      pre     = (bit_limit < {3'b0, PREAMBLE_ONES}) ? bit_limit[4:0] : PREAMBLE_ONES;
      rem_m   = bit_limit - {3'b0, pre};
      q_m     = div9(rem_m);
      oct_m   = (q_m < {1'b0, MENU_OCTETS}) ? q_m[3:0] : MENU_OCTETS;
      total_m = {3'b0, pre} + ({4'b0, oct_m} << 3) + {4'b0, oct_m};
      // CJ: whole zero octets first, then the trailer of ones
      q_c     = div9(bit_limit);
      cjb     = (q_c < CJ_OCTETS) ? ((q_c << 3) + q_c) : ((CJ_OCTETS << 3) + CJ_OCTETS);
      rem_c   = bit_limit - {3'b0, cjb};
      trl     = (rem_c < CJ_TRAILER) ? rem_c : CJ_TRAILER;
      total_c = {3'b0, cjb} + trl;

      plan.cj       = cj;
      plan.total    = cj ? total_c : total_m;
      plan.edge_pos = cj ? cjb : pre;
   end

endmodule

### sv/v8mbs_seq.sv
// Per-message state and bit selection: one accepted item, one decision.
// Depends on v8mbs_pkg and v8mbs_plan.
module v8mbs_seq import v8mbs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,        // item accepted this cycle
   input  logic       mode,
   input  logic [1:0] message_kind,
   input  logic [2:0] standard,
   input  logic [7:0] bit_limit,
   output logic       fire,        // item yields a bit
   output result_type result
);

   plan_type   plan_new;
   logic       active_ff, active_in;
   plan_type   plan_ff, plan_in;
   logic [1:0] group_ff, group_in;
   logic [7:0] position_ff, position_in;
   logic [3:0] bis_ff, bis_in;
   logic [1:0] oct_ff, oct_in;
   logic       ones;
   logic [7:0] octet;
   logic [3:0] bis_m1;
   logic [8:0] pos_next;

   v8mbs_plan u_plan (
      .cj        (message_kind[1]),
      .bit_limit (bit_limit),
      .plan      (plan_new)
   );

   always_comb begin
      ones = plan_ff.cj ? (position_ff >= {3'b0, plan_ff.edge_pos})
                        : (position_ff <  {3'b0, plan_ff.edge_pos});
      case (oct_ff)
         OCT_SYNC: octet = SYNC_OCTET;
         OCT_CALL: octet = CALL_FUNC_OCTET;
         OCT_MODL: octet = mod_low(group_ff);
         OCT_MODH: octet = MOD_HIGH_OCTET;
         default:  octet = ZERO_OCTET;
      endcase
      if (plan_ff.cj) octet = ZERO_OCTET;
      bis_m1   = bis_ff - 4'd1;
      pos_next = {1'b0, position_ff} + 9'd1;

      fire = take && (mode == MODE_NEXT) && active_ff && (position_ff < plan_ff.total);

      result.bit_res   = ones ? 1'b1 : ((bis_ff == 4'd0) ? 1'b0 : octet[bis_m1[2:0]]);
      result.bit_index = position_ff;
      result.last      = (pos_next == {1'b0, plan_ff.total});

      active_in   = active_ff;
      plan_in     = plan_ff;
      group_in    = group_ff;
      position_in = position_ff;
      bis_in      = bis_ff;
      oct_in      = oct_ff;
      if (take && mode == MODE_START) begin
         active_in   = 1'b1;
         plan_in     = plan_new;
         group_in    = group_of(standard);
         position_in = 8'd0;
         bis_in      = 4'd0;
         oct_in      = 2'd0;
      end else if (take && active_ff) begin
         if (fire) begin
            position_in = pos_next[7:0];
            if (result.last) active_in = 1'b0;
            // preamble ones leave the octet counters parked at zero
            if (plan_ff.cj || !ones) begin
               if (bis_ff == OCTET_LAST) begin
                  bis_in = 4'd0;
                  oct_in = oct_ff + 2'd1;
               end else begin
                  bis_in = bis_ff + 4'd1;
               end
            end
         end else begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         plan_ff     <= '0;
         group_ff    <= 2'd0;
         position_ff <= 8'd0;
         bis_ff      <= 4'd0;
         oct_ff      <= 2'd0;
      end else begin
         active_ff   <= active_in;
         plan_ff     <= plan_in;
         group_ff    <= group_in;
         position_ff <= position_in;
         bis_ff      <= bis_in;
         oct_ff      <= oct_in;
      end
   end

`ifndef SYNTHESIS
   a_start_loads: assert property (@(posedge clock) disable iff (reset)
      take && mode == MODE_START |=> active_ff && position_ff == 8'd0 && bis_ff == 4'd0)
      else $error("start item did not load a fresh message");
   a_fire_in_range: assert property (@(posedge clock) disable iff (reset)
      fire |-> position_ff < plan_ff.total)
      else $error("bit produced beyond message length");
   a_bis_range: assert property (@(posedge clock) disable iff (reset)
      bis_ff <= OCTET_LAST)
      else $error("octet bit counter out of range");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      fire && result.last && !(take && mode == MODE_START) |=> !active_ff)
      else $error("message still active after its final bit");
`endif

endmodule

### sv/v8_menu_bit_sequence_generator.sv
// Top level of the V.8 CM/JM/CJ bit sequencer: stream handshake and result register.
// Depends on v8mbs_pkg, v8mbs_seq (which uses v8mbs_plan).
//
// A start item (tuser = 0) latches message kind, modem standard and bit limit and
// gives no result; each following next item (tuser = 1) gives one bit of the
// message with its index and a tlast flag on the final bit. CM and JM send 20
// ones and three rounds of sync, call-function and two modulation octets; CJ
// sends three zero octets and up to 8 ones. Octets go out as a 0 start bit and
// 8 data bits LSB first; under a tight limit the ones are clipped bit by bit and
// octets that do not fit are dropped whole. Next items outside a message, or
// past its end, are consumed without a result. Throughput is one item per clock
// unless the consumer stalls; a bit appears on the rsp side in the cycle after its item
// is taken. The single result register sets that figure: req_tready stays high while
// the register is empty or being drained in the same cycle. No reset sweep; req_tready
// is held low during reset and rises as soon as reset falls.
module v8_menu_bit_sequence_generator import v8mbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [1:0] message_kind, [4:2] standard, [12:5] bit_limit
   input  logic        req_tuser,   // [0] mode: 0 start, 1 next bit
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] bit_res, [8:1] bit_index
   output logic        rsp_tlast
);

   logic       take;
   logic       fire;
   result_type result;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign take       = req_tvalid && req_tready;

   v8mbs_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .mode         (req_tuser),
      .message_kind (req_tdata[1:0]),
      .standard     (req_tdata[4:2]),
      .bit_limit    (req_tdata[12:5]),
      .fire         (fire),
      .result       (result)
   );

   // result register: loads on a new bit, holds while the consumer stalls
   always_comb begin
      rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);
      rsp_in       = fire ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_ff.bit_index, rsp_ff.bit_res};
   assign rsp_tlast  = rsp_ff.last;

endmodule

### bench/tb.sv
// Self-checking bench for v8_menu_bit_sequence_generator (CM/JM/CJ bit sequencer).
// Needs v8mbs_pkg and the block's RTL; built-in predictor, random handshake idling.
module tb;
   import v8mbs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 1500;
   localparam int TAIL_CYCLES = 8;
   localparam int SHOWN_ERRORS = 10;

   typedef enum logic [1:0] {
      KIND_CM     = 2'd0,
      KIND_JM     = 2'd1,
      KIND_CJ     = 2'd2,
      KIND_CJ_ALT = 2'd3    // upper bit set: sent as CJ
   } msg_kind_type;

   typedef enum logic [2:0] {
      STD_V21, STD_V22, STD_V22BIS, STD_V32, STD_V32BIS, STD_V34, STD_V34PLUS, STD_V90
   } modem_std_type;

   typedef struct packed {
      logic          mode;
      msg_kind_type  kind;
      modem_std_type std_sel;
      logic [7:0]    limit;
   } bit_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [1:0] message_kind, [4:2] standard, [12:5] bit_limit
   logic        req_tuser = 1'b0; // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [0] bit_res, [8:1] bit_index
   logic        rsp_tlast;

   v8_menu_bit_sequence_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Message layout, as a function of kind and limit only
   // ---------------------------------------------------------------------
   function automatic int unsigned lead_ones(input logic [7:0] lim);
      return (lim < 20) ? lim : 20;
   endfunction

   function automatic int unsigned menu_octets_fit(input logic [7:0] lim);
      int unsigned n;
      n = (lim - lead_ones(lim)) / 9;
      return (n < 12) ? n : 12;
   endfunction

   function automatic int unsigned cj_octets_fit(input logic [7:0] lim);
      int unsigned n;
      n = lim / 9;
      return (n < 3) ? n : 3;
   endfunction

   function automatic int unsigned cj_tail_ones(input logic [7:0] lim);
      int unsigned r;
      r = lim - cj_octets_fit(lim) * 9;
      return (r < 8) ? r : 8;
   endfunction

   function automatic int unsigned message_length(input logic [1:0] kind,
                                                  input logic [7:0] lim);
      if (kind[1])
         return cj_octets_fit(lim) * 9 + cj_tail_ones(lim);
      return lead_ones(lim) + menu_octets_fit(lim) * 9;
   endfunction

   // bits in one segment; menu: 0 preamble, 1..12 octets; CJ: 0..2 octets, 3 trailer
   function automatic int unsigned segment_bits(input logic [1:0] kind,
                                                input logic [7:0] lim,
                                                input int unsigned seg);
      if (kind[1]) begin
         if (seg < 3)
            return (seg < cj_octets_fit(lim)) ? 9 : 0;
         return (seg == 3) ? cj_tail_ones(lim) : 0;
      end
      if (seg == 0)
         return lead_ones(lim);
      return (seg <= menu_octets_fit(lim)) ? 9 : 0;
   endfunction

   // ---------------------------------------------------------------------
   // Sequencer predictor
   // ---------------------------------------------------------------------
   logic       seq_active = 1'b0;
   logic [1:0] seq_kind = '0;
   logic [1:0] seq_group = '0;
   logic [7:0] seq_limit = '0;
   logic [7:0] seq_pos = '0;
   logic [3:0] seq_seg = '0;
   logic [4:0] seq_bis = '0;

   result_type expected_bits[$];

   function automatic logic [7:0] menu_octet(input int unsigned seg, input logic [1:0] grp);
      logic [1:0] slot;
      logic [7:0] o;
      slot = 2'(seg - 1);
      case (slot)
         OCT_SYNC: o = SYNC_OCTET;
         OCT_CALL: o = CALL_FUNC_OCTET;
         OCT_MODL: o = (grp == 2'd0) ? 8'h00 : (grp == 2'd1) ? 8'h08 :
                       (grp == 2'd2) ? 8'h0C : 8'h0E;
         default:  o = MOD_HIGH_OCTET;
      endcase
      return o;
   endfunction

   function automatic logic [1:0] standard_group(input modem_std_type s);
      case (s)
         STD_V21:                 return 2'd0;
         STD_V22, STD_V22BIS:     return 2'd1;
         STD_V32, STD_V32BIS:     return 2'd2;
         default:                 return 2'd3;
      endcase
   endfunction

   task automatic predict_bit(input bit_request_type it);
      int unsigned len, seg, bis;
      logic        b;
      logic [7:0]  oct;
      result_type  r;
      if (it.mode == MODE_START) begin
         seq_kind   = it.kind;
         seq_group  = standard_group(it.std_sel);
         seq_limit  = it.limit;
         seq_pos    = '0;
         seq_seg    = '0;
         seq_bis    = '0;
         seq_active = 1'b1;
         return;
      end
      if (!seq_active)
         return;
      len = message_length(seq_kind, seq_limit);
      if (seq_pos >= len) begin
         seq_active = 1'b0;
         return;
      end
      seg = seq_seg;
      bis = seq_bis;
      while (seg < 15 && bis >= segment_bits(seq_kind, seq_limit, seg)) begin
         seg++;
         bis = 0;
      end
      oct = seq_kind[1] ? ZERO_OCTET : menu_octet(seg, seq_group);
      if (seq_kind[1] ? (seg == 3) : (seg == 0))
         b = 1'b1;
      else if (bis == 0)
         b = 1'b0;                           // octet start bit
      else
         b = oct[bis - 1];
      r.bit_res   = b;
      r.bit_index = seq_pos;
      r.last      = (seq_pos + 1 == len);
      expected_bits.push_back(r);
      seq_seg = 4'(seg);
      seq_bis = 5'(bis + 1);
      seq_pos = seq_pos + 8'd1;
      if (seq_pos >= len)
         seq_active = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Stimulus store
   // ---------------------------------------------------------------------
   bit_request_type request_queue[$];
   int              items_total = 0;
   int              items_accepted = 0;

   task automatic push_start(input msg_kind_type k, input modem_std_type s,
                             input logic [7:0] lim);
      bit_request_type it;
      it.mode    = MODE_START;
      it.kind    = k;
      it.std_sel = s;
      it.limit   = lim;
      request_queue.push_back(it);
      items_total++;
   endtask

   // next items carry random filler in the unused fields
   task automatic push_nexts(input int n);
      bit_request_type it;
      repeat (n) begin
         it.mode    = MODE_NEXT;
         it.kind    = msg_kind_type'($urandom_range(0, 3));
         it.std_sel = modem_std_type'($urandom_range(0, 7));
         it.limit   = 8'($urandom);
         request_queue.push_back(it);
         items_total++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: bursts of items separated by random gaps
   // ---------------------------------------------------------------------
   bit_request_type on_bus;
   int              burst_left = 1;
   int              gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_bit(on_bus);
            items_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (request_queue.size() != 0) begin
               on_bus = request_queue.pop_front();
               req_tdata  <= {3'b000, on_bus.limit, on_bus.std_sel, on_bus.kind};
               req_tuser  <= on_bus.mode;
               req_tvalid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  // a quarter of the bursts run straight into the next one
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor and receiver stall pattern
   // ---------------------------------------------------------------------
   int         mismatch_count = 0;
   int         stall_cycle = 0;
   int         stall_mode = 0;
   result_type oldest;

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= SHOWN_ERRORS)
         $display("%0t: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bits.size() == 0) begin
               note_mismatch($sformatf("unexpected bit: bit %0b index %0d last %0b",
                                       rsp_tdata[0], rsp_tdata[8:1], rsp_tlast));
            end else begin
               oldest = expected_bits.pop_front();
               if (rsp_tdata[0] !== oldest.bit_res || rsp_tdata[8:1] !== oldest.bit_index ||
                   rsp_tlast !== oldest.last)
                  note_mismatch($sformatf({"bit mismatch: expected bit %0b index %0d last %0b,",
                                           " got bit %0b index %0d last %0b"},
                                          oldest.bit_res, oldest.bit_index, oldest.last,
                                          rsp_tdata[0], rsp_tdata[8:1], rsp_tlast));
            end
         end
         // stall patterns, redrawn at random: always ready, coin flip, 1 in 4, mostly stalled
         stall_cycle++;
         if (stall_cycle % 200 == 0)
            stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom);
            2:       rsp_tready <= (stall_cycle % 4 == 0);
            default: rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      int              pick, len, n;
      msg_kind_type    k;
      modem_std_type   s;
      logic [7:0]      lim;
      bit_request_type junk;

      // directed: next with nothing running
      push_nexts(1);
      // zero limit: empty message
      push_start(KIND_CM, STD_V21, 8'd0);
      push_nexts(1);
      // one preamble bit, then a next past the end
      push_start(KIND_JM, STD_V22BIS, 8'd1);
      push_nexts(2);
      // full limit, abandoned by a new start
      push_start(KIND_CM, STD_V90, 8'd255);
      push_nexts(2);
      // CJ under a tight limit: three trailer ones only
      push_start(KIND_CJ, STD_V32, 8'd3);
      push_nexts(4);
      // kind three behaves as CJ
      push_start(KIND_CJ_ALT, STD_V34PLUS, 8'd2);
      push_nexts(3);
      // CJ at full limit, abandoned after its first bits
      push_start(KIND_CJ, STD_V34, 8'd255);
      push_nexts(3);
      push_start(KIND_JM, STD_V32BIS, 8'd255);
      push_nexts(1);

      // random: mostly whole messages, some cut short, some noise
      while (items_total < RANDOM_ITEMS + 25) begin
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            k = msg_kind_type'($urandom_range(0, 3));
            s = modem_std_type'($urandom_range(0, 7));
            case ($urandom_range(0, 3))
               0:       lim = 8'($urandom_range(0, 40));    // clipping edges
               1:       lim = 8'($urandom_range(120, 140)); // around the full menu length
               2:       lim = 8'($urandom);
               default: lim = ($urandom_range(0, 1) == 0) ? 8'd255 : 8'($urandom_range(128, 255));
            endcase
            len = message_length(k, lim);
            if (pick == 7 && len > 1)
               n = $urandom_range(1, len - 1);              // abandoned message
            else
               n = len + $urandom_range(0, 2);              // runs past its end
            push_start(k, s, lim);
            push_nexts(n);
         end else if (pick == 8) begin
            push_nexts($urandom_range(1, 3));
         end else begin
            junk = bit_request_type'($urandom);
            request_queue.push_back(junk);
            items_total++;
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted != items_total) @(posedge clock);
      while (expected_bits.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_bits.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
